/* sv/olba_pkg.sv */
// ----------------------------------------------------------------------------
// One-lane bridge arbiter package
// Shared codes, types and constants of the bridge arbiter.
// ----------------------------------------------------------------------------
package olba_pkg;

  // Codes for which side sent a car across in one tick.
  typedef enum logic [1:0] {
    CROSSED_NONE = 2'd0,
    CROSSED_A    = 2'd1,
    CROSSED_B    = 2'd2
  } crossed_e;

  localparam int unsigned LIMIT_WIDTH = 8;
  localparam int unsigned RUN_WIDTH   = 8;

  localparam logic [LIMIT_WIDTH-1:0] CROSS_LIMIT_RESET = 8'd5;
  localparam logic [RUN_WIDTH-1:0]   RUN_MAX           = 8'hFF;

  // Light and run state, passed between the top level and the step logic.
  typedef struct packed {
    logic                 green_a;
    logic                 green_b;
    logic [RUN_WIDTH-1:0] run_count;
  } light_t;

endpackage

/* sv/olba_step.sv */
// ----------------------------------------------------------------------------
// One-lane bridge arbiter step logic
// Combinational next state and result word for one tick.
// ----------------------------------------------------------------------------
module olba_step #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                                car_a_i,
  input  logic                                car_b_i,
  input  logic [olba_pkg::LIMIT_WIDTH-1:0]    cross_limit_i,
  input  logic [COUNT_WIDTH-1:0]              queue_a_i,
  input  logic [COUNT_WIDTH-1:0]              queue_b_i,
  input  olba_pkg::light_t                    light_i,
  output logic [COUNT_WIDTH-1:0]              queue_a_o,
  output logic [COUNT_WIDTH-1:0]              queue_b_o,
  output olba_pkg::light_t                    light_o,
  output olba_pkg::crossed_e                  crossed_o
);

  localparam logic [COUNT_WIDTH-1:0] QueueMax = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] queue_a_add;
  logic [COUNT_WIDTH-1:0] queue_b_add;
  logic                   wait_a;
  logic                   wait_b;
  logic                   send;
  logic [olba_pkg::RUN_WIDTH-1:0] run_inc;

  // Arrivals join the queues first; a full queue drops the arrival.
  always_comb begin
    queue_a_add = queue_a_i;
    queue_b_add = queue_b_i;
    if (car_a_i && (queue_a_i != QueueMax)) begin
      queue_a_add = queue_a_i + COUNT_WIDTH'(1);
    end
    if (car_b_i && (queue_b_i != QueueMax)) begin
      queue_b_add = queue_b_i + COUNT_WIDTH'(1);
    end
  end

  assign wait_a  = (queue_a_add != '0);
  assign wait_b  = (queue_b_add != '0);
  assign run_inc = (light_i.run_count == olba_pkg::RUN_MAX) ?
                   olba_pkg::RUN_MAX :
                   light_i.run_count + olba_pkg::RUN_WIDTH'(1);

  // Decide the lights and whether a car crosses this tick.
  always_comb begin
    light_o = light_i;
    send    = 1'b0;
    if (wait_a != wait_b) begin
      // Only one side waits: it gets the bridge and the run restarts.
      light_o.green_a   = wait_a;
      light_o.green_b   = ~wait_a;
      light_o.run_count = olba_pkg::RUN_WIDTH'(1);
      send              = 1'b1;
    end else if (wait_a) begin
      send = 1'b1;
      if (!light_i.green_a && !light_i.green_b) begin
        // Both red when contention starts: side A wins the tie.
        light_o.green_a   = 1'b1;
        light_o.run_count = run_inc;
      end else if (light_i.run_count < cross_limit_i) begin
        light_o.run_count = run_inc;
      end else begin
        // Run limit reached: swap the lights and start a new run.
        light_o.green_a   = ~light_i.green_a;
        light_o.green_b   = ~light_i.green_b;
        light_o.run_count = olba_pkg::RUN_WIDTH'(1);
      end
    end
  end

  // One car leaves the queue on the green side.
  always_comb begin
    queue_a_o = queue_a_add;
    queue_b_o = queue_b_add;
    crossed_o = olba_pkg::CROSSED_NONE;
    if (send) begin
      if (light_o.green_a) begin
        crossed_o = olba_pkg::CROSSED_A;
        if (queue_a_add != '0) begin
          queue_a_o = queue_a_add - COUNT_WIDTH'(1);
        end
      end else begin
        crossed_o = olba_pkg::CROSSED_B;
        if (queue_b_add != '0) begin
          queue_b_o = queue_b_add - COUNT_WIDTH'(1);
        end
      end
    end
  end

endmodule

/* sv/one_lane_bridge_arbiter.sv */
// ----------------------------------------------------------------------------
// One-lane bridge arbiter
// Arbitrates a one-lane bridge between two queues of cars, one tick per word.
// ----------------------------------------------------------------------------
// Each accepted input word is one tick: it carries the arrival flags of both
// sides, and the block returns exactly one result word with both lights, both
// waiting counts and the side that sent a car across. A word is accepted in
// every cycle the input is not stalled; its result goes to the result
// register, or to the skid register if that is full. The arbitration state
// is updated in the same cycle the word is accepted, so ticks follow at one
// per clock while the input is not stalled. A two-word output buffer keeps
// input flowing while one result waits; the input stalls only when both are
// full. cross_limit may be written only while the block is idle and sets how
// many cars one side sends in a row while both sides wait; it resets to 5.
module one_lane_bridge_arbiter #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration
  input  logic                             cross_limit_we_i,
  input  logic [olba_pkg::LIMIT_WIDTH-1:0] cross_limit_i,
  // Input words
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             car_a_i,
  input  logic                             car_b_i,
  // Result words
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             green_a_o,
  output logic                             green_b_o,
  output logic [COUNT_WIDTH-1:0]           waiting_a_o,
  output logic [COUNT_WIDTH-1:0]           waiting_b_o,
  output logic [1:0]                       crossed_o
);

  // Result word layout used by the output buffer.
  typedef struct packed {
    logic                   green_a;
    logic                   green_b;
    logic [COUNT_WIDTH-1:0] waiting_a;
    logic [COUNT_WIDTH-1:0] waiting_b;
    olba_pkg::crossed_e     crossed;
  } result_t;

  logic [olba_pkg::LIMIT_WIDTH-1:0] cross_limit_q;
  logic [COUNT_WIDTH-1:0]           queue_a_q, queue_a_d;
  logic [COUNT_WIDTH-1:0]           queue_b_q, queue_b_d;
  olba_pkg::light_t                 light_q, light_d;
  olba_pkg::crossed_e               crossed_d;
  result_t                          result_d;
  result_t                          out_q;
  result_t                          skid_q;
  logic                             out_valid_q;
  logic                             skid_valid_q;
  logic                             in_take;
  logic                             out_take;

  assign in_stall_o = skid_valid_q;
  assign in_take    = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_limit_q <= olba_pkg::CROSS_LIMIT_RESET;
    end else if (cross_limit_we_i) begin
      cross_limit_q <= cross_limit_i;
    end
  end

  // Next state and result of one tick.
  olba_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .car_a_i      (car_a_i),
    .car_b_i      (car_b_i),
    .cross_limit_i(cross_limit_q),
    .queue_a_i    (queue_a_q),
    .queue_b_i    (queue_b_q),
    .light_i      (light_q),
    .queue_a_o    (queue_a_d),
    .queue_b_o    (queue_b_d),
    .light_o      (light_d),
    .crossed_o    (crossed_d)
  );

  assign result_d = '{
    green_a:   light_d.green_a,
    green_b:   light_d.green_b,
    waiting_a: queue_a_d,
    waiting_b: queue_b_d,
    crossed:   crossed_d
  };

  // Arbitration state advances on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_a_q <= '0;
      queue_b_q <= '0;
      light_q   <= '0;
    end else if (in_take) begin
      queue_a_q <= queue_a_d;
      queue_b_q <= queue_b_d;
      light_q   <= light_d;
    end
  end

  // Output buffer: result register with a skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_take) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload of the output buffer.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_take) begin
      if (!out_valid_q || out_take) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign green_a_o   = out_q.green_a;
  assign green_b_o   = out_q.green_b;
  assign waiting_a_o = out_q.waiting_a;
  assign waiting_b_o = out_q.waiting_b;
  assign crossed_o   = out_q.crossed;

  // The two lights are never green together.
  a_lights_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(light_q.green_a && light_q.green_b))
    else $error("both lights green");

  // The skid register only fills behind a full result register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid while result register empty");

  // A car crosses only from the side whose light is green in that result.
  a_cross_on_green: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.crossed != olba_pkg::CROSSED_A) || out_q.green_a) &&
                    ((out_q.crossed != olba_pkg::CROSSED_B) || out_q.green_b))
    else $error("car crossed against a red light");

  // A buffered word is not lost while the sink stalls.
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid word dropped while stalled");

endmodule
